### rtl/mcaf_pkg.sv
// ----------------------------------------------------------------------------
// Motor current average filter package
// Shared widths, register indexes and control types of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mcaf_pkg;

    // Field widths
    localparam int SMP_W      = 10;   // raw converter sample
    localparam int OFS_W      = 10;   // zero offset and phase offsets
    localparam int FS_W       = 16;   // full scale multiplier
    localparam int MAG_W      = 11;   // rectified magnitude and average
    localparam int SCL_W      = 17;   // scaled current
    localparam int DIFF_W     = 13;   // signed difference before rectifying
    localparam int PROD_W     = MAG_W + FS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHA_OFS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHB_OFS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd3;

    // Register reset values
    localparam logic [OFS_W-1:0] ZERO_OFS_RST   = 10'd512;
    localparam logic [FS_W-1:0]  FULL_SCALE_RST = 16'd1024;

    // Arithmetic constants
    localparam logic [MAG_W-1:0] MAG_MAX     = 11'd2047;
    localparam int               SCALE_SHIFT = 10;
    localparam int               ROUND_SCALE = 512;

    // Default window size
    localparam int WINDOW_LOG2_DEF = 4;

    // Window control from the pipeline to the window unit
    typedef struct packed {
        logic take;     // input transfer: start the read of the oldest entry
        logic adv;      // item leaves the first stage: update the sum, write back
    } t_win_ctl;

endpackage : mcaf_pkg

`default_nettype wire

### rtl/mcaf_if.sv
// ----------------------------------------------------------------------------
// Motor current average filter channels
// Valid/ready channels for the sample pairs and for the filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcaf_in_if;
    logic                        valid;
    logic                        ready;
    logic [mcaf_pkg::SMP_W-1:0]  phase_a_sample;
    logic [mcaf_pkg::SMP_W-1:0]  phase_b_sample;

    modport source (output valid, output phase_a_sample, output phase_b_sample,
                    input ready);
    modport sink   (input valid, input phase_a_sample, input phase_b_sample,
                    output ready);
endinterface : mcaf_in_if

interface mcaf_out_if;
    logic                        valid;
    logic                        ready;
    logic [mcaf_pkg::MAG_W-1:0]  filtered_current;
    logic [mcaf_pkg::SCL_W-1:0]  scaled_current;

    modport source (output valid, output filtered_current, output scaled_current,
                    input ready);
    modport sink   (input valid, input filtered_current, input scaled_current,
                    output ready);
endinterface : mcaf_out_if

`default_nettype wire

### rtl/mcaf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module mcaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : mcaf_ram

`default_nettype wire

### rtl/mcaf_mag.sv
// ----------------------------------------------------------------------------
// Phase magnitude unit
// Removes the zero offset and the phase offset from one raw sample, then
// rectifies and saturates the difference.
// ----------------------------------------------------------------------------
`default_nettype none

module mcaf_mag (
    input  wire logic        [mcaf_pkg::SMP_W-1:0] i_sample,
    input  wire logic        [mcaf_pkg::OFS_W-1:0] i_zero_ofs,
    input  wire logic signed [mcaf_pkg::OFS_W-1:0] i_phase_ofs,
    output      logic        [mcaf_pkg::MAG_W-1:0] o_mag
);
    import mcaf_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] abs_val;

    // Signed difference, wide enough for every operand combination
    assign diff = $signed({{(DIFF_W-SMP_W){1'b0}}, i_sample})
                - $signed({{(DIFF_W-OFS_W){1'b0}}, i_zero_ofs})
                - DIFF_W'(i_phase_ofs);

    // Rectify
    assign abs_val = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // Saturate to the magnitude range
    assign o_mag = (abs_val > DIFF_W'(MAG_MAX)) ? MAG_MAX : abs_val[MAG_W-1:0];

endmodule : mcaf_mag

`default_nettype wire

### rtl/mcaf_window.sv
// ----------------------------------------------------------------------------
// Sliding window unit
// Keeps the window entries in a RAM, reads the entry that is about to be
// replaced, updates the running sum and writes the new magnitude back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcaf_window #(
    parameter int WINDOW_LOG2 = mcaf_pkg::WINDOW_LOG2_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mcaf_pkg::t_win_ctl            i_ctl,
    input  wire logic [mcaf_pkg::MAG_W-1:0]    i_cur,
    output      logic [mcaf_pkg::MAG_W-1:0]    o_avg
);
    import mcaf_pkg::*;

    localparam int DEPTH = 1 << WINDOW_LOG2;
    localparam int SUM_W = MAG_W + WINDOW_LOG2;
    localparam int RND_W = SUM_W + 1;

    logic [WINDOW_LOG2-1:0] r_wr_pos;
    logic [DEPTH-1:0]       r_vld;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    logic [MAG_W-1:0]       r_cur;
    logic [WINDOW_LOG2-1:0] r_pos;
    logic                   r_old_vld;
    logic [MAG_W-1:0]       ram_rdata;
    logic [MAG_W-1:0]       old_val;
    logic [RND_W-1:0]       rnd_sum;

    // Window storage: read on transfer, written when the item moves on
    mcaf_ram #(
        .WIDTH (MAG_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.adv),
        .i_waddr (r_pos),
        .i_wdata (r_cur),
        .i_re    (i_ctl.take),
        .i_raddr (r_wr_pos),
        .o_rdata (ram_rdata)
    );

    // Write position and per-entry valid bits; an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_vld    <= '0;
            r_sum    <= '0;
        end else begin
            if (i_ctl.take) begin
                r_wr_pos <= r_wr_pos + 1'b1;
            end
            if (i_ctl.adv) begin
                r_vld[r_pos] <= 1'b1;
                r_sum        <= n_sum;
            end
        end
    end

    // Item held while its old entry is read
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_cur     <= i_cur;
            r_pos     <= r_wr_pos;
            r_old_vld <= r_vld[r_wr_pos];
        end
    end

    // Running sum: drop the oldest entry, add the new one
    assign old_val = r_old_vld ? ram_rdata : '0;
    assign n_sum   = r_sum - SUM_W'(old_val) + SUM_W'(r_cur);

    // Rounded average of the updated window
    assign rnd_sum = {1'b0, n_sum} + RND_W'(1 << (WINDOW_LOG2 - 1));
    assign o_avg   = rnd_sum[WINDOW_LOG2 +: MAG_W];

endmodule : mcaf_window

`default_nettype wire

### rtl/motor_current_average_filter.sv
// ----------------------------------------------------------------------------
// Motor current average filter
// Rectified peak phase current, averaged over a sliding window and scaled.
// ----------------------------------------------------------------------------
// The filter takes one pair of phase samples per clock, while the output side
// accepts results, and returns one result per pair, in order. The window of
// 2^WINDOW_LOG2 entries lives in a small RAM with a registered read; each
// transfer reads the entry it replaces, and the sum update and write-back
// follow when the item leaves the first stage, so consecutive items never
// touch the same entry and a full rate of one item per cycle is sustained
// while the output drains. Entries not yet written count as zero through
// per-entry valid bits that reset clears at once, so no clearing pass is
// needed. The output register and the two stages before it each accept a
// new item while the stage after them drains. Write configuration registers
// only while the filter is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_current_average_filter #(
    parameter int WINDOW_LOG2 = mcaf_pkg::WINDOW_LOG2_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mcaf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mcaf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mcaf_in_if.sink                              i_sample,
    mcaf_out_if.source                           o_result
);
    import mcaf_pkg::*;

    // Configuration registers
    logic        [OFS_W-1:0] r_zero_ofs;
    logic signed [OFS_W-1:0] r_pha_ofs;
    logic signed [OFS_W-1:0] r_phb_ofs;
    logic        [FS_W-1:0]  r_full_scale;

    // Pipeline control
    logic       r_a_valid;
    logic       r_b_valid;
    logic       r_c_valid;
    logic       c_ready;
    logic       b_ready;
    logic       b_adv;
    logic       in_xfer;
    t_win_ctl   win_ctl;

    // Payload
    logic [MAG_W-1:0]  mag_a;
    logic [MAG_W-1:0]  mag_b;
    logic [MAG_W-1:0]  cur;
    logic [MAG_W-1:0]  win_avg;
    logic [MAG_W-1:0]  r_b_avg;
    logic [MAG_W-1:0]  r_c_avg;
    logic [SCL_W-1:0]  r_c_scaled;
    logic [PROD_W-1:0] prod;
    logic [PROD_W:0]   prod_rnd;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_ofs   <= ZERO_OFS_RST;
            r_pha_ofs    <= '0;
            r_phb_ofs    <= '0;
            r_full_scale <= FULL_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZERO_OFS:   r_zero_ofs   <= i_cfg_data[OFS_W-1:0];
                CFG_PHA_OFS:    r_pha_ofs    <= i_cfg_data[OFS_W-1:0];
                CFG_PHB_OFS:    r_phb_ofs    <= i_cfg_data[OFS_W-1:0];
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data[FS_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-phase magnitudes and the larger of the two
    mcaf_mag u_mag_a (
        .i_sample    (i_sample.phase_a_sample),
        .i_zero_ofs  (r_zero_ofs),
        .i_phase_ofs (r_pha_ofs),
        .o_mag       (mag_a)
    );

    mcaf_mag u_mag_b (
        .i_sample    (i_sample.phase_b_sample),
        .i_zero_ofs  (r_zero_ofs),
        .i_phase_ofs (r_phb_ofs),
        .o_mag       (mag_b)
    );

    assign cur = (mag_a > mag_b) ? mag_a : mag_b;

    // Ready chain: each stage takes an item when it is empty or drains
    assign c_ready          = !r_c_valid || o_result.ready;
    assign b_ready          = !r_b_valid || c_ready;
    assign b_adv            = r_b_valid && c_ready;
    assign i_sample.ready   = !r_a_valid || b_ready;
    assign in_xfer          = i_sample.valid && i_sample.ready;
    // Window control, take first and adv second
    assign win_ctl          = {in_xfer, r_a_valid && b_ready};

    // Window read, sum update and write-back
    mcaf_window #(
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_cur   (cur),
        .o_avg   (win_avg)
    );

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_a_valid <= i_sample.valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Average register
    always_ff @(posedge i_clk) begin
        if (win_ctl.adv) begin
            r_b_avg <= win_avg;
        end
    end

    // Scaling with rounding
    assign prod     = PROD_W'(r_b_avg) * PROD_W'(r_full_scale);
    assign prod_rnd = {1'b0, prod} + (PROD_W + 1)'(ROUND_SCALE);

    // Output register
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_avg    <= r_b_avg;
            r_c_scaled <= prod_rnd[SCALE_SHIFT +: SCL_W];
        end
    end

    assign o_result.valid            = r_c_valid;
    assign o_result.filtered_current = r_c_avg;
    assign o_result.scaled_current   = r_c_scaled;

endmodule : motor_current_average_filter

`default_nettype wire

### rtl/mcaf_checker.sv
// ----------------------------------------------------------------------------
// Motor current average filter checker
// Port-level assertions on the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mcaf_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_ready,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic [mcaf_pkg::MAG_W-1:0] i_filtered,
    input  wire logic [mcaf_pkg::SCL_W-1:0] i_scaled
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its value until its transfer.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_filtered) && $stable(i_scaled))
        else $error("stalled result changed or dropped");

    // With the output side ready, the input side is never held off.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    // A transfer reaches the output register while the output side drains.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("result missing after pipeline latency");

endmodule : mcaf_checker

bind motor_current_average_filter mcaf_checker u_mcaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_filtered  (o_result.filtered_current),
    .i_scaled    (o_result.scaled_current)
);

`default_nettype wire
